[sv/bdq_pkg.sv]
// Package with the request, response and cell control types of the bounded deque.
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [2:0] {
    OP_SCAN       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_FROM_FRONT
  } cell_op_e;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] item_value;
    logic [1:0]               status;
    logic                     last_of_run;
  } rsp_t;

  typedef struct packed {
    logic signed [ValueW-1:0] load;
    logic signed [ValueW-1:0] left;
    logic signed [ValueW-1:0] right;
    logic signed [ValueW-1:0] front;
  } cell_links_t;

endpackage

[sv/bdq_cell.sv]
// One storage cell of the deque chain, taking data from itself, the input, a neighbor or the first cell.
`timescale 1ns / 1ps
module bdq_cell (
  input  logic                                clk_i,
  input  bdq_pkg::cell_op_e                   op_i,
  input  bdq_pkg::cell_links_t                links_i,
  output logic signed [bdq_pkg::ValueW-1:0]   data_o
);
  import bdq_pkg::*;

  logic signed [ValueW-1:0] data_q;
  logic signed [ValueW-1:0] data_d;

  always_comb begin
    case (op_i)
      CELL_HOLD:       data_d = data_q;
      CELL_LOAD:       data_d = links_i.load;
      CELL_FROM_LEFT:  data_d = links_i.left;
      CELL_FROM_RIGHT: data_d = links_i.right;
      CELL_FROM_FRONT: data_d = links_i.front;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[sv/bounded_deque_with_scan.sv]
// Top level of the bounded deque: a chain of storage cells with a scan sequencer.
`timescale 1ns / 1ps
// The deque holds up to DEPTH signed 32-bit values in a chain of cells, with the
// front value always in the first cell. Push front shifts the whole chain one
// cell back, pop front shifts it one cell forward, push back writes the cell
// just past the stored values, and pop back reads the last stored cell, so each
// of these requests gives one response through a single output register. A scan
// holds off new requests while it runs: each cycle that the output register is
// free, the occupied cells rotate by one toward the front and the first cell is
// sent out, so after the last value the chain is back in its original order.
// Requests with an undefined operation are taken and give no response. The store
// needs no clearing after reset; only the fill count and control state are reset.
module bounded_deque_with_scan #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bdq_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bdq_pkg::rsp_t out_o
);
  import bdq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_left_q, scan_left_d;
  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q;
  rsp_t            rsp_d;
  logic            out_load;
  logic            out_free;
  logic            in_accept;
  logic            scan_step;
  logic            full;
  logic signed [ValueW-1:0] back_value;

  cell_op_e                 cell_op   [DEPTH];
  cell_links_t              cell_link [DEPTH];
  logic signed [ValueW-1:0] cell_data [DEPTH];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign scan_step  = busy_q && out_free;
  assign full       = (count_q == CntW'(DEPTH));

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_comb begin
      cell_link[g].load  = in_req_i.value;
      cell_link[g].front = cell_data[0];
      cell_link[g].left  = (g == 0) ? in_req_i.value : cell_data[(g == 0) ? 0 : g - 1];
      cell_link[g].right = (g == DEPTH - 1) ? cell_data[g]
                                            : cell_data[(g == DEPTH - 1) ? g : g + 1];
    end

    bdq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .links_i (cell_link[g]),
      .data_o  (cell_data[g])
    );
  end

  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CntW'(i + 1) == count_q) begin
        back_value = cell_data[i];
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    scan_left_d = scan_left_q;
    busy_d      = busy_q;
    out_load    = 1'b0;
    rsp_d       = '{item_value: '0, status: ST_OK, last_of_run: 1'b1};
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end

    if (scan_step) begin
      out_load          = 1'b1;
      rsp_d.item_value  = cell_data[0];
      rsp_d.last_of_run = (scan_left_q == CntW'(1));
      scan_left_d       = scan_left_q - CntW'(1);
      if (scan_left_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
      for (int i = 0; i < DEPTH; i++) begin
        if (CntW'(i + 1) < count_q) begin
          cell_op[i] = CELL_FROM_RIGHT;
        end else if (CntW'(i + 1) == count_q) begin
          cell_op[i] = CELL_FROM_FRONT;
        end
      end
    end else if (in_accept) begin
      case (in_req_i.operation)
        OP_SCAN: begin
          out_load = 1'b1;
          if (count_q == '0) begin
            rsp_d.status = ST_EMPTY;
          end else begin
            out_load    = 1'b0;
            busy_d      = 1'b1;
            scan_left_d = count_q;
          end
        end
        OP_PUSH_FRONT: begin
          out_load = 1'b1;
          if (full) begin
            rsp_d.status = ST_FULL;
          end else begin
            count_d = count_q + CntW'(1);
            for (int i = 0; i < DEPTH; i++) begin
              cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
            end
          end
        end
        OP_PUSH_BACK: begin
          out_load = 1'b1;
          if (full) begin
            rsp_d.status = ST_FULL;
          end else begin
            count_d = count_q + CntW'(1);
            for (int i = 0; i < DEPTH; i++) begin
              if (CntW'(i) == count_q) begin
                cell_op[i] = CELL_LOAD;
              end
            end
          end
        end
        OP_POP_FRONT: begin
          out_load = 1'b1;
          if (count_q == '0) begin
            rsp_d.status = ST_EMPTY;
          end else begin
            rsp_d.item_value = cell_data[0];
            count_d          = count_q - CntW'(1);
            for (int i = 0; i < DEPTH; i++) begin
              cell_op[i] = CELL_FROM_RIGHT;
            end
          end
        end
        OP_POP_BACK: begin
          out_load = 1'b1;
          if (count_q == '0) begin
            rsp_d.status = ST_EMPTY;
          end else begin
            rsp_d.item_value = back_value;
            count_d          = count_q - CntW'(1);
          end
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_left_q <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      scan_left_q <= scan_left_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("Fill count exceeds the depth.");

  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (scan_left_q != '0) && (scan_left_q <= count_q))
    else $error("Scan counter out of range.");

  a_scan_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_step && scan_left_q == CntW'(1)) |=> !busy_q && out_valid_o && out_o.last_of_run)
    else $error("Scan did not end with a final response.");

  a_scan_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> $stable(count_q))
    else $error("Fill count changed during a scan.");
`endif

endmodule

[test/bounded_deque_with_scan_tb.sv]
// Self-checking testbench for the bounded deque with scan.
`timescale 1ns / 1ps
module bounded_deque_with_scan_tb;
  import bdq_pkg::*;

  localparam int unsigned QueueDepth    = 16;
  localparam int unsigned RandomItems   = 230;
  localparam int unsigned QuietTail     = 40;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned MaxReports    = 20;

  localparam logic [2:0] OP_RESERVED_A = 3'd5;
  localparam logic [2:0] OP_RESERVED_B = 3'd6;
  localparam logic [2:0] OP_RESERVED_C = 3'd7;

  localparam logic signed [ValueW-1:0] ValueMin = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] ValueMax = 32'sh7fff_ffff;

  class deque_scoreboard;
    logic signed [ValueW-1:0] contents[$];
    rsp_t expected_rsps[$];
    int unsigned failures = 0;
    int unsigned requests = 0;
    int unsigned responses = 0;
    int unsigned scans = 0;
    int unsigned longest_scan = 0;
    int unsigned full_drops = 0;
    int unsigned empty_results = 0;

    function void add_expected(logic signed [ValueW-1:0] item, status_e st, logic last);
      rsp_t r;
      r.item_value  = item;
      r.status      = st;
      r.last_of_run = last;
      expected_rsps.push_back(r);
    endfunction

    function void note_request(req_t req);
      requests++;
      case (req.operation)
        OP_SCAN: begin
          scans++;
          if (contents.size() == 0) begin
            empty_results++;
            add_expected('0, ST_EMPTY, 1'b1);
          end else begin
            if (contents.size() > longest_scan) longest_scan = contents.size();
            foreach (contents[i]) add_expected(contents[i], ST_OK, i == contents.size() - 1);
          end
        end
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (contents.size() >= QueueDepth) begin
            full_drops++;
            add_expected('0, ST_FULL, 1'b1);
          end else begin
            if (req.operation == OP_PUSH_FRONT) contents.push_front(req.value);
            else contents.push_back(req.value);
            add_expected('0, ST_OK, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (contents.size() == 0) begin
            empty_results++;
            add_expected('0, ST_EMPTY, 1'b1);
          end else if (req.operation == OP_POP_FRONT) begin
            add_expected(contents.pop_front(), ST_OK, 1'b1);
          end else begin
            add_expected(contents.pop_back(), ST_OK, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      responses++;
      if (expected_rsps.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $error("response with no request waiting: item_value %0d, status %0d",
                 got.item_value, got.status);
        return;
      end
      want = expected_rsps.pop_front();
      if (got.item_value !== want.item_value) begin
        failures++;
        if (failures <= MaxReports)
          $error("item_value: expected %0d, got %0d", want.item_value, got.item_value);
      end
      if (got.status !== want.status) begin
        failures++;
        if (failures <= MaxReports)
          $error("status: expected %0d, got %0d", want.status, got.status);
      end
      if (got.last_of_run !== want.last_of_run) begin
        failures++;
        if (failures <= MaxReports)
          $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
      end
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_o;

  deque_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  bounded_deque_with_scan #(
    .DEPTH(QueueDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 9);
    end
    out_stall_i <= (stall_left != 0);
  end

  // Requests are noted before responses are checked, so expected results are queued ahead of their checks.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) sb.check_response(out_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic signed [ValueW-1:0] value);
    req_t req;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req.operation = op;
    req.value     = value;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_left;
    int unsigned phase_no;
    int unsigned roll;
    logic [2:0] op;
    logic signed [ValueW-1:0] value;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 20;
    stall_pct     = 20;
    send_request(OP_SCAN, 32'sd11);
    send_request(OP_POP_FRONT, 32'sd12);
    send_request(OP_POP_BACK, 32'sd13);
    send_request(OP_PUSH_BACK, ValueMin);
    send_request(OP_PUSH_FRONT, ValueMax);
    send_request(OP_PUSH_BACK, -32'sd1);
    send_request(OP_PUSH_FRONT, 32'sd0);
    send_request(OP_PUSH_BACK, 32'sh5555_5555);
    send_request(OP_PUSH_FRONT, 32'shaaaa_aaaa);
    send_request(OP_SCAN, ValueMax);
    send_request(OP_RESERVED_A, ValueMin);
    send_request(OP_RESERVED_B, -32'sd1);
    send_request(OP_RESERVED_C, 32'sd7);
    send_request(OP_POP_FRONT, ValueMin);
    send_request(OP_POP_BACK, ValueMax);
    send_request(OP_SCAN, 32'sd0);
    send_request(OP_POP_FRONT, 32'sd0);

    sent       = 0;
    phase_left = 0;
    phase_no   = 0;
    while (sent < RandomItems) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 40);
        phase_no++;
        case ($urandom_range(0, 2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 15;
          default: send_idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 35;
        endcase
        if (phase_no == 3) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
      end
      if (RandomItems - sent <= QuietTail) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      phase_left--;

      roll = $urandom_range(0, 99);
      case ((phase_no - 1) % 3)
        0: op = roll < 80 ? OP_PUSH_BACK : roll < 90 ? OP_POP_BACK : roll < 97 ? OP_SCAN
                : OP_RESERVED_A;
        1: op = roll < 15 ? OP_PUSH_BACK : roll < 80 ? OP_POP_BACK : roll < 95 ? OP_SCAN
                : OP_RESERVED_A;
        default: op = roll < 40 ? OP_PUSH_BACK : roll < 75 ? OP_POP_BACK : roll < 95 ? OP_SCAN
                      : OP_RESERVED_A;
      endcase
      if (op == OP_PUSH_BACK && $urandom_range(0, 1)) op = OP_PUSH_FRONT;
      if (op == OP_POP_BACK && $urandom_range(0, 1)) op = OP_POP_FRONT;
      if (op == OP_RESERVED_A) op = OP_RESERVED_A + 3'($urandom_range(0, 2));

      case ($urandom_range(0, 19))
        0: value = ValueMin;
        1: value = ValueMax;
        2: value = '0;
        3: value = -32'sd1;
        default: value = $urandom();
      endcase

      send_request(op, value);
      if (op <= OP_POP_BACK) sent++;
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Checked %0d responses from %0d requests: %0d scans (longest %0d entries),",
             sb.responses, sb.requests, sb.scans, sb.longest_scan);
    $display("%0d pushes dropped while full and %0d requests met an empty queue.",
             sb.full_drops, sb.empty_results);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
